// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, held off while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/ptrd_pkg.sv =====
package ptrd_pkg;

    localparam int NUM_TASKS = 8;
    localparam int TASK_ID_W = 4;
    localparam int TIME_W    = 16;
    localparam int CMD_W     = 3;
    localparam int KIND_W    = 3;
    localparam int STATE_W   = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_SCHEDULE = 3'd1,
        CMD_DONE     = 3'd2,
        CMD_READ     = 3'd3,
        CMD_LOAD     = 3'd4
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK       = 3'd0,
        KIND_DISPATCH  = 3'd1,
        KIND_CLEARED   = 3'd2,
        KIND_PASS_DONE = 3'd3,
        KIND_READ      = 3'd4
    } kind_t;

    typedef enum logic [STATE_W-1:0] {
        ST_SUSPENDED = 2'd0,
        ST_READY     = 2'd1,
        ST_RUNNING   = 2'd2,
        ST_OVERTIME  = 2'd3
    } task_state_t;

    typedef struct packed {
        logic tick;
        logic load;
        logic done;
        logic start;
        logic adv;
    } cell_ctrl_t;

    typedef struct packed {
        task_state_t status;
        logic        tok;
        logic        fwd;
    } cell_stat_t;

endpackage

// ===== hw/rtl/ptrd_cell.sv =====
module ptrd_cell
    import ptrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [TIME_W-1:0] period,
    input  logic [TIME_W-1:0] deadline,
    input  logic              fwd_in,
    output cell_stat_t        stat
);

    logic [TIME_W-1:0] per_reg, per_next;
    logic [TIME_W-1:0] dl_reg, dl_next;
    logic [TIME_W-1:0] cd_reg, cd_next;
    logic [TIME_W-1:0] el_reg, el_next;
    task_state_t       st_reg, st_next;
    logic              tok_reg, tok_next;

    logic [TIME_W-1:0] el_inc;
    logic [TIME_W-1:0] cd_dec;
    logic [TIME_W-1:0] per_ld;
    logic [TIME_W-1:0] el_t;
    task_state_t       st_t;

    always_comb
    begin
        el_inc = (el_reg == '1) ? el_reg : el_reg + TIME_W'(1);
        cd_dec = cd_reg - TIME_W'(1);
        per_ld = (period == '0) ? TIME_W'(1) : period;

        per_next = per_reg;
        dl_next  = dl_reg;
        cd_next  = cd_reg;
        el_next  = el_reg;
        st_next  = st_reg;
        tok_next = tok_reg;
        st_t     = st_reg;
        el_t     = el_reg;

        if (ctrl.tick)
        begin
            if (st_reg == ST_READY || st_reg == ST_RUNNING)
            begin
                el_t = el_inc;
                if (el_inc >= dl_reg)
                begin
                    st_t = ST_OVERTIME;
                end
            end
            if (cd_dec == '0)
            begin
                cd_next = per_reg;
                el_t    = '0;
                if (st_t != ST_OVERTIME)
                begin
                    st_t = ST_READY;
                end
            end
            else
            begin
                cd_next = cd_dec;
            end
            st_next = st_t;
            el_next = el_t;
        end

        if (ctrl.load)
        begin
            per_next = per_ld;
            dl_next  = deadline;
            cd_next  = per_ld;
            el_next  = '0;
            st_next  = ST_SUSPENDED;
        end

        if (ctrl.done && st_reg == ST_RUNNING)
        begin
            st_next = ST_SUSPENDED;
        end

        if (ctrl.start)
        begin
            tok_next = 1'b1;
        end
        else if (ctrl.adv)
        begin
            tok_next = fwd_in;
            if (tok_reg)
            begin
                case (st_reg)
                    ST_READY:    st_next = ST_RUNNING;
                    ST_OVERTIME: st_next = ST_SUSPENDED;
                    default:     st_next = st_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_reg <= '1;
            dl_reg  <= '1;
            cd_reg  <= '1;
            el_reg  <= '0;
            st_reg  <= ST_SUSPENDED;
            tok_reg <= 1'b0;
        end
        else
        begin
            per_reg <= per_next;
            dl_reg  <= dl_next;
            cd_reg  <= cd_next;
            el_reg  <= el_next;
            st_reg  <= st_next;
            tok_reg <= tok_next;
        end
    end

    assign stat.status = st_reg;
    assign stat.tok    = tok_reg;
    assign stat.fwd    = tok_reg && (st_reg != ST_OVERTIME);

endmodule

// ===== hw/rtl/periodic_task_release_deadline_monitor_core.sv =====
// Tick-driven task monitor: a row of NUM_TASKS cells, one per task, each holding that task's
// period, deadline, release countdown, elapsed count and state. Tick, done, read, load and
// unknown commands give one result each; all cells age in parallel on a tick.
// A schedule pass walks a token down the cell row one cell per cycle unless a waiting result
// is stalled: the token enters the first cell with the accepted transaction, visits each
// cell in turn, and the pass-done result follows the last cell. A pass that meets an overtime
// task ends there. It gives one result per dispatched task and a final pass-done or
// overtime-cleared result.
// No new transaction is taken while a pass runs. A registered output stage sits on the
// result side, so the next transaction is taken in the same cycle a waiting result leaves.
`include "assert_macros.svh"

module periodic_task_release_deadline_monitor_core
    import ptrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // task_id[3:0], period[19:4], deadline[35:20]
    input  logic [CMD_W-1:0]     s_tuser,   // cmd[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // result_task[3:0], task_state[5:4], overtime_seen[6]
    output logic [KIND_W-1:0]    m_tuser,   // kind[2:0]
    output logic                 m_tlast
);

    logic [TASK_ID_W-1:0] in_id;
    logic [TIME_W-1:0]    in_period;
    logic [TIME_W-1:0]    in_deadline;
    logic [CMD_W-1:0]     in_cmd;

    assign in_id       = s_tdata[TASK_ID_W-1:0];
    assign in_period   = s_tdata[TASK_ID_W +: TIME_W];
    assign in_deadline = s_tdata[TASK_ID_W+TIME_W +: TIME_W];
    assign in_cmd      = s_tuser;

    logic                 busy_reg, busy_next;
    logic                 tok_end_reg, tok_end_next;
    logic                 m_valid_reg, m_valid_next;
    kind_t                m_kind_reg, m_kind_next;
    logic [TASK_ID_W-1:0] m_task_reg, m_task_next;
    task_state_t          m_state_reg, m_state_next;
    logic                 m_ot_reg, m_ot_next;
    logic                 m_last_reg, m_last_next;

    logic       accept;
    logic       adv;
    logic       start;
    cell_ctrl_t ctrl [NUM_TASKS];
    cell_stat_t stat [NUM_TASKS];
    logic [NUM_TASKS-1:0] tok_vec;

    logic                 hit_disp;
    logic                 hit_clr;
    logic [TASK_ID_W-1:0] hit_idx;
    task_state_t          sel_state;

    assign s_tready = !busy_reg && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign adv      = busy_reg && (!m_valid_reg || m_tready);
    assign start    = accept && (in_cmd == CMD_SCHEDULE);

    genvar g;
    generate
        for (g = 0; g < NUM_TASKS; g++)
        begin : g_cell
            logic fwd_in;
            logic sel;

            assign sel = (in_id == TASK_ID_W'(g));
            assign ctrl[g].tick  = accept && (in_cmd == CMD_TICK);
            assign ctrl[g].load  = accept && (in_cmd == CMD_LOAD) && sel;
            assign ctrl[g].done  = accept && (in_cmd == CMD_DONE) && sel;
            assign ctrl[g].start = (g == 0) ? start : 1'b0;
            assign ctrl[g].adv   = adv;
            assign tok_vec[g]    = stat[g].tok;

            if (g == 0)
            begin : g_head
                assign fwd_in = 1'b0;
            end
            else
            begin : g_body
                assign fwd_in = stat[g-1].fwd;
            end

            ptrd_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl[g]),
                .period   (in_period),
                .deadline (in_deadline),
                .fwd_in   (fwd_in),
                .stat     (stat[g])
            );
        end
    endgenerate

    always_comb
    begin
        hit_disp  = 1'b0;
        hit_clr   = 1'b0;
        hit_idx   = '0;
        sel_state = ST_SUSPENDED;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            if (stat[i].tok && stat[i].status == ST_READY)
            begin
                hit_disp = 1'b1;
                hit_idx  = TASK_ID_W'(i);
            end
            if (stat[i].tok && stat[i].status == ST_OVERTIME)
            begin
                hit_clr = 1'b1;
                hit_idx = TASK_ID_W'(i);
            end
            if (in_id == TASK_ID_W'(i))
            begin
                sel_state = stat[i].status;
            end
        end
    end

    always_comb
    begin
        busy_next    = busy_reg;
        tok_end_next = tok_end_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_task_next  = m_task_reg;
        m_state_next = m_state_reg;
        m_ot_next    = m_ot_reg;
        m_last_next  = m_last_reg;

        if (accept)
        begin
            m_valid_next = 1'b1;
            m_kind_next  = KIND_ACK;
            m_task_next  = '0;
            m_state_next = ST_SUSPENDED;
            m_ot_next    = 1'b0;
            m_last_next  = 1'b1;
            case (in_cmd)
                CMD_SCHEDULE:
                begin
                    m_valid_next = 1'b0;
                    busy_next    = 1'b1;
                    tok_end_next = 1'b0;
                end
                CMD_DONE:
                begin
                    m_task_next  = in_id;
                    m_state_next = (sel_state == ST_RUNNING) ? ST_SUSPENDED : sel_state;
                end
                CMD_READ:
                begin
                    m_kind_next  = KIND_READ;
                    m_task_next  = in_id;
                    m_state_next = sel_state;
                end
                CMD_LOAD:
                begin
                    m_task_next = in_id;
                end
                default:
                begin
                    m_task_next = '0;
                end
            endcase
        end
        else if (adv)
        begin
            tok_end_next = stat[NUM_TASKS-1].fwd;
            if (hit_clr)
            begin
                m_valid_next = 1'b1;
                m_kind_next  = KIND_CLEARED;
                m_task_next  = hit_idx;
                m_state_next = ST_SUSPENDED;
                m_ot_next    = 1'b1;
                m_last_next  = 1'b1;
                busy_next    = 1'b0;
            end
            else if (hit_disp)
            begin
                m_valid_next = 1'b1;
                m_kind_next  = KIND_DISPATCH;
                m_task_next  = hit_idx;
                m_state_next = ST_RUNNING;
                m_ot_next    = 1'b0;
                m_last_next  = 1'b0;
            end
            else if (tok_end_reg)
            begin
                m_valid_next = 1'b1;
                m_kind_next  = KIND_PASS_DONE;
                m_task_next  = '0;
                m_state_next = ST_SUSPENDED;
                m_ot_next    = 1'b0;
                m_last_next  = 1'b1;
                busy_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            tok_end_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            m_kind_reg  <= KIND_ACK;
            m_task_reg  <= '0;
            m_state_reg <= ST_SUSPENDED;
            m_ot_reg    <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            tok_end_reg <= tok_end_next;
            m_valid_reg <= m_valid_next;
            m_kind_reg  <= m_kind_next;
            m_task_reg  <= m_task_next;
            m_state_reg <= m_state_next;
            m_ot_reg    <= m_ot_next;
            m_last_reg  <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_ot_reg, m_state_reg, m_task_reg};

    `ASSERT_CLK(a_one_token, busy_reg |-> $onehot({tok_end_reg, tok_vec}), "pass token lost or duplicated")
    `ASSERT_CLK(a_no_stray_token, !busy_reg |-> ({tok_end_reg, tok_vec} == '0), "token outside a pass")
    `ASSERT_CLK(a_pass_starts_at_head, $rose(busy_reg) |-> tok_vec[0], "pass did not start at first cell")
    `ASSERT_CLK(a_pass_ends_on_last, $fell(busy_reg) |-> (m_valid_reg && m_last_reg), "pass ended without final result")

endmodule

// ===== test/tb_periodic_task_release_deadline_monitor_core.sv =====
`timescale 1ns / 1ps

module tb_periodic_task_release_deadline_monitor_core;
    import ptrd_pkg::*;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int NUM_PHASES       = 4;
    localparam int RANDOM_PER_PHASE = 80;
    localparam int DRAIN_CYCLES     = 2 * NUM_TASKS + 4;
    localparam int NUM_DIRECTED     = 25;
    localparam int PAD_W            = S_TDATA_W - TASK_ID_W - 2 * TIME_W;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

    localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 65, 0, 21};
    localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 65, 21};

    typedef struct packed {
        kind_t                 kind;
        logic [TASK_ID_W-1:0]  tsk;
        task_state_t           st;
        logic                  ot;
        logic                  last;
    } task_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [TASK_ID_W-1:0]  id;
        logic [TIME_W-1:0]     per;
        logic [TIME_W-1:0]     dl;
        logic                  typed;
        task_result_t          want;
    } command_row_t;

    localparam task_result_t NO_WANT = '0;
    localparam task_result_t ACK_NONE = '{KIND_ACK, 4'd0, ST_SUSPENDED, 1'b0, 1'b1};

    localparam command_row_t DIRECTED[NUM_DIRECTED] = '{
        '{CMD_READ, 4'd0, 16'h0000, 16'h0000, 1'b1,
          '{KIND_READ, 4'd0, ST_SUSPENDED, 1'b0, 1'b1}},
        '{CMD_READ, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1,
          '{KIND_READ, 4'd15, ST_SUSPENDED, 1'b0, 1'b1}},
        '{CMD_SCHEDULE, 4'd0, 16'h0000, 16'h0000, 1'b1,
          '{KIND_PASS_DONE, 4'd0, ST_SUSPENDED, 1'b0, 1'b1}},
        '{CMD_TICK, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, ACK_NONE},
        '{CMD_DONE, 4'd3, 16'h0000, 16'h0000, 1'b1,
          '{KIND_ACK, 4'd3, ST_SUSPENDED, 1'b0, 1'b1}},
        '{CMD_DONE, 4'd15, 16'h0000, 16'h0000, 1'b1,
          '{KIND_ACK, 4'd15, ST_SUSPENDED, 1'b0, 1'b1}},
        '{CMD_SPARE_HI, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, ACK_NONE},
        '{CMD_SPARE_LO, 4'd9, 16'h5A5A, 16'hA5A5, 1'b1, ACK_NONE},
        '{CMD_LOAD, 4'd0, 16'h0000, 16'h0000, 1'b1,
          '{KIND_ACK, 4'd0, ST_SUSPENDED, 1'b0, 1'b1}},
        '{CMD_LOAD, 4'd7, 16'hFFFF, 16'hFFFF, 1'b1,
          '{KIND_ACK, 4'd7, ST_SUSPENDED, 1'b0, 1'b1}},
        '{CMD_LOAD, 4'd15, 16'h0002, 16'h0001, 1'b1,
          '{KIND_ACK, 4'd15, ST_SUSPENDED, 1'b0, 1'b1}},
        '{CMD_LOAD, 4'd1, 16'h0002, 16'h0001, 1'b1,
          '{KIND_ACK, 4'd1, ST_SUSPENDED, 1'b0, 1'b1}},
        '{CMD_LOAD, 4'd2, 16'h0001, 16'h0003, 1'b1,
          '{KIND_ACK, 4'd2, ST_SUSPENDED, 1'b0, 1'b1}},
        '{CMD_LOAD, 4'd3, 16'h0001, 16'hFFFF, 1'b1,
          '{KIND_ACK, 4'd3, ST_SUSPENDED, 1'b0, 1'b1}},
        '{CMD_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{CMD_READ, 4'd0, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{CMD_SCHEDULE, 4'd0, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{CMD_DONE, 4'd2, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{CMD_READ, 4'd2, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{CMD_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{CMD_TICK, 4'd0, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{CMD_SCHEDULE, 4'd0, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{CMD_SCHEDULE, 4'd0, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{CMD_SPARE_MID, 4'd0, 16'h0000, 16'h0000, 1'b0, NO_WANT},
        '{CMD_READ, 4'd7, 16'h0000, 16'h0000, 1'b0, NO_WANT}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    logic [TIME_W-1:0]     period_tbl   [NUM_TASKS];
    logic [TIME_W-1:0]     deadline_tbl [NUM_TASKS];
    logic [TIME_W-1:0]     countdown    [NUM_TASKS];
    logic [TIME_W-1:0]     elapsed      [NUM_TASKS];
    task_state_t           status       [NUM_TASKS];

    task_result_t          step_results[$];
    task_result_t          pending_results[$];
    task_result_t          head_result;

    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    idle_cycles;
    int                    mismatch_count;
    int                    commands_sent;
    int                    results_seen;
    int                    dispatches;
    int                    clears;

    periodic_task_release_deadline_monitor_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void add_result(kind_t kind, logic [TASK_ID_W-1:0] tsk,
                                       task_state_t st, logic ot, logic last);
        task_result_t r;
        r = '{kind, tsk, st, ot, last};
        step_results.push_back(r);
    endfunction

    function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [TASK_ID_W-1:0] id,
                                          logic [TIME_W-1:0] per, logic [TIME_W-1:0] dl);
        logic        in_range;
        logic        cleared;
        task_state_t st;
        in_range = (id < NUM_TASKS);
        cleared  = 1'b0;
        st       = ST_SUSPENDED;
        step_results.delete();
        case (cmd)
            CMD_TICK:
            begin
                for (int i = 0; i < NUM_TASKS; i++)
                begin
                    if (status[i] == ST_READY || status[i] == ST_RUNNING)
                    begin
                        if (elapsed[i] != 16'hFFFF)
                            elapsed[i] = elapsed[i] + 16'd1;
                        if (elapsed[i] >= deadline_tbl[i])
                            status[i] = ST_OVERTIME;
                    end
                    countdown[i] = countdown[i] - 16'd1;
                    if (countdown[i] == 16'd0)
                    begin
                        countdown[i] = period_tbl[i];
                        elapsed[i]   = 16'd0;
                        if (status[i] != ST_OVERTIME)
                            status[i] = ST_READY;
                    end
                end
                add_result(KIND_ACK, 4'd0, ST_SUSPENDED, 1'b0, 1'b1);
            end
            CMD_SCHEDULE:
            begin
                for (int i = 0; i < NUM_TASKS && !cleared; i++)
                begin
                    if (status[i] == ST_OVERTIME)
                    begin
                        status[i] = ST_SUSPENDED;
                        cleared   = 1'b1;
                        add_result(KIND_CLEARED, TASK_ID_W'(i), ST_SUSPENDED, 1'b1, 1'b1);
                    end
                    else if (status[i] == ST_READY)
                    begin
                        status[i] = ST_RUNNING;
                        add_result(KIND_DISPATCH, TASK_ID_W'(i), ST_RUNNING, 1'b0, 1'b0);
                    end
                end
                if (!cleared)
                    add_result(KIND_PASS_DONE, 4'd0, ST_SUSPENDED, 1'b0, 1'b1);
            end
            CMD_DONE:
            begin
                if (in_range)
                begin
                    if (status[id] == ST_RUNNING)
                        status[id] = ST_SUSPENDED;
                    st = status[id];
                end
                add_result(KIND_ACK, id, st, 1'b0, 1'b1);
            end
            CMD_READ:
            begin
                if (in_range)
                    st = status[id];
                add_result(KIND_READ, id, st, 1'b0, 1'b1);
            end
            CMD_LOAD:
            begin
                if (in_range)
                begin
                    period_tbl[id]   = (per == 16'd0) ? 16'd1 : per;
                    deadline_tbl[id] = dl;
                    countdown[id]    = period_tbl[id];
                    elapsed[id]      = 16'd0;
                    status[id]       = ST_SUSPENDED;
                end
                add_result(KIND_ACK, id, ST_SUSPENDED, 1'b0, 1'b1);
            end
            default:
                add_result(KIND_ACK, 4'd0, ST_SUSPENDED, 1'b0, 1'b1);
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_command(command_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.cmd;
        s_tdata  <= {{PAD_W{1'b0}}, row.dl, row.per, row.id};
        do
            @(posedge clk);
        while (!s_tready);
        apply_command(row.cmd, row.id, row.per, row.dl);
        if (row.typed)
            pending_results.push_back(row.want);
        else
            foreach (step_results[k])
                pending_results.push_back(step_results[k]);
        commands_sent++;
    endtask

    task automatic send_random_command();
        command_row_t         row;
        int                   pick;
        logic [TASK_ID_W-1:0] busy[$];
        row      = '0;
        row.id   = TASK_ID_W'($urandom_range(15));
        row.per  = TIME_W'($urandom());
        row.dl   = TIME_W'($urandom());
        pick     = $urandom_range(99);
        if (pick < 38)
            row.cmd = CMD_TICK;
        else if (pick < 58)
            row.cmd = CMD_SCHEDULE;
        else if (pick < 72)
        begin
            row.cmd = CMD_DONE;
            for (int i = 0; i < NUM_TASKS; i++)
                if (status[i] == ST_RUNNING)
                    busy.push_back(TASK_ID_W'(i));
            if (busy.size() != 0 && $urandom_range(9) < 7)
                row.id = busy[$urandom_range(busy.size() - 1)];
        end
        else if (pick < 80)
            row.cmd = CMD_READ;
        else if (pick < 96)
        begin
            row.cmd = CMD_LOAD;
            if ($urandom_range(9) < 8)
            begin
                row.id  = TASK_ID_W'($urandom_range(NUM_TASKS - 1));
                row.per = TIME_W'($urandom_range(6));
                row.dl  = TIME_W'($urandom_range(8));
            end
        end
        else
            row.cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        send_command(row);
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser == KIND_DISPATCH)
                dispatches++;
            if (m_tuser == KIND_CLEARED)
                clears++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d, data 0x%0h", m_tuser, m_tdata);
                mismatch_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                check_field("kind", head_result.kind, m_tuser);
                check_field("result_task", head_result.tsk, m_tdata[3:0]);
                check_field("task_state", head_result.st, m_tdata[5:4]);
                check_field("overtime_seen", head_result.ot, m_tdata[6]);
                check_field("last", head_result.last, m_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        idle_cycles    = 0;
        mismatch_count = 0;
        commands_sent  = 0;
        results_seen   = 0;
        dispatches     = 0;
        clears         = 0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            period_tbl[i]   = 16'hFFFF;
            deadline_tbl[i] = 16'hFFFF;
            countdown[i]    = 16'hFFFF;
            elapsed[i]      = 16'd0;
            status[i]       = ST_SUSPENDED;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < NUM_DIRECTED; k++)
            send_command(DIRECTED[k]);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // hold off until every outstanding result has drained
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (pending_results.size() != 0);
            send_idle_pct  = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_random_command();
        end

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands (%0d directed) and checked %0d results,",
                 commands_sent, NUM_DIRECTED, results_seen);
        $display("with %0d dispatches and %0d overtime clears across four idle/stall mixes.",
                 dispatches, clears);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
